>>> sv/gcn_pkg.sv
`timescale 1ns / 1ps

package gcn_pkg;

   localparam int ANGLE_FRAC_BITS = 22;

   localparam int LAT_W  = 30;
   localparam int LON_W  = 31;
   localparam int COG_W  = 31;
   localparam int DIST_W = 30;
   localparam int BEAR_W = 31;
   localparam int CORR_W = 31;

   localparam int REQ_DATA_W = 96;
   localparam int RSP_DATA_W = 96;
   localparam int RSP_USER_W = 2;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 31;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_WP_LAT,
      CSR_WP_LON,
      CSR_WP_VALID,
      CSR_NAV_EN
   } csr_index_type;

   localparam int TURN_W   = 32;
   localparam int DEG_W    = 33;
   localparam int MAG_W    = 32;
   localparam int TRIG_W   = 34;
   localparam int ZW       = 34;
   localparam int VEC_IN_W = 34;
   localparam int VEC_W    = 36;
   localparam int Q_FRAC   = 30;

   localparam int SQ_IN_W   = 61;
   localparam int SQ_W      = 62;
   localparam int SQ_STAGES = 31;
   localparam int SQ_TOP    = 60;
   localparam int ROOT_W    = 31;

   localparam int D45_W       = 33;
   localparam logic [D45_W-1:0] DIV45_MUL = 33'd6108397933;
   localparam int DIV45_SHIFT = 38;
   localparam int RD_W        = 6;
   localparam int D360_W      = 24;
   localparam logic [D360_W-1:0] DIV360_MUL = 24'd11930465;
   localparam int D360_SHIFT  = 32;

   localparam logic signed [TRIG_W-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;
   localparam logic signed [ZW-1:0] QUARTER_TURN = 34'sd1073741824;
   localparam logic signed [ZW-1:0] HALF_TURN    = 34'sd2147483648;

   localparam logic [30:0] CIRC_NM_Q16 = 31'd1416532620;
   localparam logic [DIST_W-1:0] DIST_MAX = 30'd707788800;

   localparam longint BEAR_LIMIT = ((64'd71999 << ANGLE_FRAC_BITS) + 64'd199) / 64'd200;
   localparam longint BEAR_RND   = 64'd1 << (31 - ANGLE_FRAC_BITS);
   localparam longint HALF_DEG   = 64'd180 << ANGLE_FRAC_BITS;
   localparam longint FULL_DEG   = 64'd360 << ANGLE_FRAC_BITS;

   typedef logic signed [TRIG_W-1:0] trig_type;
   typedef logic signed [ZW-1:0] zang_type;
   typedef logic signed [VEC_IN_W-1:0] vin_type;

   function automatic logic [TURN_W-1:0] atan_turn(input int idx);
      logic [TURN_W-1:0] val;
      case (idx)
         0:  val = 32'h20000000;
         1:  val = 32'h12E4051E;
         2:  val = 32'h09FB385B;
         3:  val = 32'h051111D4;
         4:  val = 32'h028B0D43;
         5:  val = 32'h0145D7E1;
         6:  val = 32'h00A2F61E;
         7:  val = 32'h00517C55;
         8:  val = 32'h0028BE53;
         9:  val = 32'h00145F2F;
         10: val = 32'h000A2F98;
         11: val = 32'h000517CC;
         12: val = 32'h00028BE6;
         13: val = 32'h000145F3;
         14: val = 32'h0000A2FA;
         15: val = 32'h0000517D;
         16: val = 32'h000028BE;
         17: val = 32'h0000145F;
         18: val = 32'h00000A30;
         19: val = 32'h00000518;
         20: val = 32'h0000028C;
         21: val = 32'h00000146;
         22: val = 32'h000000A3;
         23: val = 32'h00000051;
         24: val = 32'h00000029;
         25: val = 32'h00000014;
         26: val = 32'h0000000A;
         27: val = 32'h00000005;
         28: val = 32'h00000003;
         29: val = 32'h00000001;
         30: val = 32'h00000001;
         default: val = 32'h00000000;
      endcase
      return val;
   endfunction

endpackage

>>> sv/gcn_deg2turn.sv
`timescale 1ns / 1ps

module gcn_deg2turn import gcn_pkg::*; #(
   parameter int SH = 10
) (
   input  logic                     clock,
   input  logic                     enable,
   input  logic signed [DEG_W-1:0]  deg,
   output logic [TURN_W-1:0]        turn
);

   localparam int PROD_W = MAG_W + D45_W;
   localparam int QD_W   = PROD_W - DIV45_SHIFT;
   localparam int FN_W   = RD_W + SH + 1;
   localparam int FP_W   = FN_W + D360_W;
   localparam int Q_W    = 41;

   logic [MAG_W-1:0]  mag_in;
   logic [MAG_W-1:0]  mag_ff;
   logic [PROD_W-1:0] prod_in;
   logic [PROD_W-1:0] prod_ff;
   logic              neg1_ff;

   logic [QD_W-1:0]   qd_in;
   logic [MAG_W-1:0]  rd_full;
   logic [QD_W-1:0]   qd_ff;
   logic [RD_W-1:0]   rd_ff;
   logic              neg2_ff;

   logic [FN_W-1:0]   frac_num;
   logic [FP_W-1:0]   frac_prod;
   logic [Q_W-1:0]    q_val;
   logic [TURN_W-1:0] turn_in;
   logic [TURN_W-1:0] turn_ff;

   // |d| split as 45*qd + rd so the wide product stays near 32 x 32
   always_comb begin
      mag_in  = deg[DEG_W-1] ? MAG_W'(-deg) : MAG_W'(deg);
      prod_in = PROD_W'(mag_in) * PROD_W'(DIV45_MUL);
      qd_in   = prod_ff[PROD_W-1:DIV45_SHIFT];
      rd_full = mag_ff - (MAG_W'(qd_in) * MAG_W'(45));
      frac_num  = FN_W'({rd_ff, {SH{1'b0}}}) + FN_W'(180);
      frac_prod = FP_W'(frac_num) * FP_W'(DIV360_MUL);
      q_val     = (Q_W'(qd_ff) << (SH - 3)) + Q_W'(frac_prod >> D360_SHIFT);
      turn_in   = neg2_ff ? TURN_W'(-q_val) : TURN_W'(q_val);
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         mag_ff  <= mag_in;
         prod_ff <= prod_in;
         neg1_ff <= deg[DEG_W-1];
         qd_ff   <= qd_in;
         rd_ff   <= rd_full[RD_W-1:0];
         neg2_ff <= neg1_ff;
         turn_ff <= turn_in;
      end
   end

   assign turn = turn_ff;

endmodule

>>> sv/gcn_rotate.sv
`timescale 1ns / 1ps

module gcn_rotate import gcn_pkg::*; #(
   parameter int STEPS = 24
) (
   input  logic              clock,
   input  logic              enable,
   input  logic [TURN_W-1:0] angle,
   output trig_type          cos_out,
   output trig_type          sin_out
);

   zang_type z0_in;
   logic     neg0_in;

   trig_type x_ff [0:STEPS];
   trig_type y_ff [0:STEPS];
   zang_type z_ff [0:STEPS];
   logic     neg_ff [0:STEPS];

   trig_type x_in [1:STEPS];
   trig_type y_in [1:STEPS];
   zang_type z_in [1:STEPS];

   trig_type cos_ff;
   trig_type sin_ff;

   // fold into the right half plane, flip sign at the end
   always_comb begin
      z0_in   = ZW'($signed(angle));
      neg0_in = 1'b0;
      if (z0_in > QUARTER_TURN) begin
         z0_in   = z0_in - HALF_TURN;
         neg0_in = 1'b1;
      end else if (z0_in < -QUARTER_TURN) begin
         z0_in   = z0_in + HALF_TURN;
         neg0_in = 1'b1;
      end
   end

   always_comb begin
      for (int i = 0; i < STEPS; i++) begin
         if (z_ff[i] >= 0) begin
            x_in[i+1] = x_ff[i] - (y_ff[i] >>> i);
            y_in[i+1] = y_ff[i] + (x_ff[i] >>> i);
            z_in[i+1] = z_ff[i] - $signed(ZW'(atan_turn(i)));
         end else begin
            x_in[i+1] = x_ff[i] + (y_ff[i] >>> i);
            y_in[i+1] = y_ff[i] - (x_ff[i] >>> i);
            z_in[i+1] = z_ff[i] + $signed(ZW'(atan_turn(i)));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         x_ff[0]   <= CORDIC_GAIN_Q30;
         y_ff[0]   <= '0;
         z_ff[0]   <= z0_in;
         neg_ff[0] <= neg0_in;
         for (int i = 1; i <= STEPS; i++) begin
            x_ff[i]   <= x_in[i];
            y_ff[i]   <= y_in[i];
            z_ff[i]   <= z_in[i];
            neg_ff[i] <= neg_ff[i-1];
         end
         cos_ff <= neg_ff[STEPS] ? -x_ff[STEPS] : x_ff[STEPS];
         sin_ff <= neg_ff[STEPS] ? -y_ff[STEPS] : y_ff[STEPS];
      end
   end

   assign cos_out = cos_ff;
   assign sin_out = sin_ff;

endmodule

>>> sv/gcn_vector.sv
`timescale 1ns / 1ps

module gcn_vector import gcn_pkg::*; #(
   parameter int STEPS = 24
) (
   input  logic     clock,
   input  logic     enable,
   input  vin_type  x,
   input  vin_type  y,
   output zang_type z_out
);

   typedef logic signed [VEC_W-1:0] vec_type;

   vec_type  x0_in;
   vec_type  y0_in;
   zang_type z0_in;

   vec_type  x_ff [0:STEPS];
   vec_type  y_ff [0:STEPS];
   zang_type z_ff [0:STEPS];
   logic     zero_ff [0:STEPS];

   vec_type  x_in [1:STEPS];
   vec_type  y_in [1:STEPS];
   zang_type z_in [1:STEPS];

   zang_type z_out_ff;

   always_comb begin
      x0_in = VEC_W'(x);
      y0_in = VEC_W'(y);
      z0_in = '0;
      if (x < 0) begin
         x0_in = -x0_in;
         y0_in = -y0_in;
         z0_in = HALF_TURN;
      end
   end

   always_comb begin
      for (int i = 0; i < STEPS; i++) begin
         if (y_ff[i] >= 0) begin
            x_in[i+1] = x_ff[i] + (y_ff[i] >>> i);
            y_in[i+1] = y_ff[i] - (x_ff[i] >>> i);
            z_in[i+1] = z_ff[i] + $signed(ZW'(atan_turn(i)));
         end else begin
            x_in[i+1] = x_ff[i] - (y_ff[i] >>> i);
            y_in[i+1] = y_ff[i] + (x_ff[i] >>> i);
            z_in[i+1] = z_ff[i] - $signed(ZW'(atan_turn(i)));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         x_ff[0]    <= x0_in;
         y_ff[0]    <= y0_in;
         z_ff[0]    <= z0_in;
         zero_ff[0] <= (x == 0) && (y == 0);
         for (int i = 1; i <= STEPS; i++) begin
            x_ff[i]    <= x_in[i];
            y_ff[i]    <= y_in[i];
            z_ff[i]    <= z_in[i];
            zero_ff[i] <= zero_ff[i-1];
         end
         z_out_ff <= zero_ff[STEPS] ? '0 : z_ff[STEPS];
      end
   end

   assign z_out = z_out_ff;

endmodule

>>> sv/gcn_isqrt.sv
`timescale 1ns / 1ps

module gcn_isqrt import gcn_pkg::*; (
   input  logic               clock,
   input  logic               enable,
   input  logic [SQ_IN_W-1:0] val,
   output logic [ROOT_W-1:0]  root
);

   logic [SQ_IN_W-1:0] v_ff  [1:SQ_STAGES];
   logic [SQ_W-1:0]    r_ff  [1:SQ_STAGES];
   logic [SQ_IN_W-1:0] v_src [0:SQ_STAGES-1];
   logic [SQ_W-1:0]    r_src [0:SQ_STAGES-1];
   logic [SQ_IN_W-1:0] v_in  [1:SQ_STAGES];
   logic [SQ_W-1:0]    r_in  [1:SQ_STAGES];
   logic [SQ_W-1:0]    trial [0:SQ_STAGES-1];

   // one root bit per stage
   always_comb begin
      v_src[0] = val;
      r_src[0] = '0;
      for (int k = 1; k < SQ_STAGES; k++) begin
         v_src[k] = v_ff[k];
         r_src[k] = r_ff[k];
      end
      for (int k = 0; k < SQ_STAGES; k++) begin
         trial[k] = r_src[k] + (SQ_W'(1) << (SQ_TOP - 2 * k));
         if (SQ_W'(v_src[k]) >= trial[k]) begin
            v_in[k+1] = SQ_IN_W'(SQ_W'(v_src[k]) - trial[k]);
            r_in[k+1] = (r_src[k] >> 1) + (SQ_W'(1) << (SQ_TOP - 2 * k));
         end else begin
            v_in[k+1] = v_src[k];
            r_in[k+1] = r_src[k] >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         for (int k = 1; k <= SQ_STAGES; k++) begin
            v_ff[k] <= v_in[k];
            r_ff[k] <= r_in[k];
         end
      end
   end

   assign root = r_ff[SQ_STAGES][ROOT_W-1:0];

endmodule

>>> sv/gcn_delay.sv
`timescale 1ns / 1ps

module gcn_delay #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             enable,
   input  logic [WIDTH-1:0] din,
   output logic [WIDTH-1:0] dout
);

   logic [WIDTH-1:0] stage_ff [0:DEPTH-1];

   always_ff @(posedge clock) begin
      if (enable) begin
         stage_ff[0] <= din;
         for (int i = 1; i < DEPTH; i++) begin
            stage_ff[i] <= stage_ff[i-1];
         end
      end
   end

   assign dout = stage_ff[DEPTH-1];

endmodule

>>> sv/great_circle_nav_solver.sv
`timescale 1ns / 1ps
// throughput: one word per cycle; the whole pipeline holds while rsp_tvalid waits on rsp_tready
// depth is set by the rotation cordic, the 31-stage square root and the vectoring cordic in series
// reset: synchronous, clears the waypoint registers and all pipeline valid bits

module great_circle_nav_solver import gcn_pkg::*; #(
   parameter int CORDIC_STEPS = 24
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // position_latitude, position_longitude, course_over_ground, zero pad
   input  logic [REQ_DATA_W-1:0]  req_tdata,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // distance_nm, bearing_to_target, steer_correction, zero pad
   output logic [RSP_DATA_W-1:0]  rsp_tdata,
   // distance_valid, steer_valid
   output logic [RSP_USER_W-1:0]  rsp_tuser,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   localparam int LAT_SH  = 32 - ANGLE_FRAC_BITS;
   localparam int HALF_SH = 31 - ANGLE_FRAC_BITS;
   localparam int LAT_LEN = 2 * CORDIC_STEPS + 45;
   localparam int PROD_W  = 2 * TRIG_W;
   localparam int A_W     = PROD_W + 1;
   localparam int DP_W    = 66;
   localparam int BP_W    = 41;
   localparam int CR_W    = 33;

   localparam logic signed [A_W-1:0]  Q60_ONE  = A_W'(64'sd1 << SQ_TOP);
   localparam logic signed [CR_W-1:0] HALF_D   = CR_W'(HALF_DEG);
   localparam logic signed [CR_W-1:0] FULL_D   = CR_W'(FULL_DEG);
   localparam logic [BEAR_W-1:0]      BEAR_LIM = BEAR_W'(BEAR_LIMIT);

   logic signed [LAT_W-1:0] wp_lat_ff;
   logic signed [LON_W-1:0] wp_lon_ff;
   logic                    wp_valid_ff;
   logic                    nav_en_ff;
   logic [LAT_LEN-1:0]      valid_ff;
   logic                    adv;

   logic signed [LAT_W-1:0] lat1;
   logic signed [LON_W-1:0] lon1;
   logic [COG_W-1:0]        cog;
   logic signed [DEG_W-1:0] d_lat1, d_lat2, d_dlat, d_dlon;
   logic [TURN_W-1:0]       t_lat1, t_lat2, t_hdlat, t_hdlon, t_dlon;
   trig_type                c1, s1, c2, s2, chlat, shlat, chlon, shlon, cd, sd;

   logic signed [PROD_W-1:0] m1_cc_ff, m1_ll_ff, m1_sdc2_ff, m1_c1s2_ff, m1_s1c2_ff;
   trig_type                 m1_shlon_ff, m1_cd_ff;
   logic signed [PROD_W-1:0] m2_pq_ff, m2_t3_ff, m2_ll_ff;
   trig_type                 m2_shlon_ff, m2_y_ff, m2_t1_ff;
   logic signed [PROD_W-1:0] m3_qs_ff, m3_ll_ff;
   vin_type                  m3_x_ff, m3_y_ff;
   logic signed [A_W-1:0]    a_sum;
   logic signed [A_W-1:0]    a_clamp;
   logic [SQ_IN_W-1:0]       m4_a_ff, m4_na_ff;
   vin_type                  m4_x_ff, m4_y_ff;

   logic [ROOT_W-1:0]           root_a, root_na;
   logic [2*VEC_IN_W-1:0]       bxy_d;
   zang_type                    vd_z, vb_z;
   logic [COG_W-1:0]            cog_d;

   logic [ZW-1:0]     two_z;
   logic [DP_W-1:0]   f1_dprod_ff;
   logic [BP_W-1:0]   f1_bprod_ff;
   logic [DP_W-33:0]  dist_raw;
   logic [BEAR_W-1:0] bdeg_raw;
   logic [DIST_W-1:0] f2_dist_ff;
   logic [BEAR_W-1:0] f2_bdeg_ff;

   logic signed [CR_W-1:0] corr_in;
   logic [DIST_W-1:0]      out_dist_ff;
   logic [BEAR_W-1:0]      out_bear_ff;
   logic [CORR_W-1:0]      out_corr_ff;
   logic                   out_dvalid_ff;
   logic                   out_svalid_ff;

   assign adv        = !valid_ff[LAT_LEN-1] || rsp_tready;
   assign req_tready = adv;
   assign csr_ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_lat_ff   <= '0;
         wp_lon_ff   <= '0;
         wp_valid_ff <= 1'b0;
         nav_en_ff   <= 1'b0;
      end else if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_WP_LAT:   wp_lat_ff   <= csr_data[LAT_W-1:0];
            CSR_WP_LON:   wp_lon_ff   <= csr_data[LON_W-1:0];
            CSR_WP_VALID: wp_valid_ff <= csr_data[0];
            CSR_NAV_EN:   nav_en_ff   <= csr_data[0];
            default:      wp_valid_ff <= wp_valid_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[LAT_LEN-2:0], req_tvalid};
      end
   end

   // angle conversion
   assign lat1   = req_tdata[LAT_W-1:0];
   assign lon1   = req_tdata[LAT_W+LON_W-1:LAT_W];
   assign cog    = req_tdata[LAT_W+LON_W+COG_W-1:LAT_W+LON_W];
   assign d_lat1 = DEG_W'(lat1);
   assign d_lat2 = DEG_W'(wp_lat_ff);
   assign d_dlat = DEG_W'(wp_lat_ff) - DEG_W'(lat1);
   assign d_dlon = DEG_W'(wp_lon_ff) - DEG_W'(lon1);

   gcn_deg2turn #(.SH(LAT_SH)) u_cv_lat1 (
      .clock(clock), .enable(adv), .deg(d_lat1), .turn(t_lat1));
   gcn_deg2turn #(.SH(LAT_SH)) u_cv_lat2 (
      .clock(clock), .enable(adv), .deg(d_lat2), .turn(t_lat2));
   gcn_deg2turn #(.SH(HALF_SH)) u_cv_hdlat (
      .clock(clock), .enable(adv), .deg(d_dlat), .turn(t_hdlat));
   gcn_deg2turn #(.SH(HALF_SH)) u_cv_hdlon (
      .clock(clock), .enable(adv), .deg(d_dlon), .turn(t_hdlon));
   gcn_deg2turn #(.SH(LAT_SH)) u_cv_dlon (
      .clock(clock), .enable(adv), .deg(d_dlon), .turn(t_dlon));

   gcn_rotate #(.STEPS(CORDIC_STEPS)) u_rot_lat1 (
      .clock(clock), .enable(adv), .angle(t_lat1), .cos_out(c1), .sin_out(s1));
   gcn_rotate #(.STEPS(CORDIC_STEPS)) u_rot_lat2 (
      .clock(clock), .enable(adv), .angle(t_lat2), .cos_out(c2), .sin_out(s2));
   gcn_rotate #(.STEPS(CORDIC_STEPS)) u_rot_hdlat (
      .clock(clock), .enable(adv), .angle(t_hdlat), .cos_out(chlat), .sin_out(shlat));
   gcn_rotate #(.STEPS(CORDIC_STEPS)) u_rot_hdlon (
      .clock(clock), .enable(adv), .angle(t_hdlon), .cos_out(chlon), .sin_out(shlon));
   gcn_rotate #(.STEPS(CORDIC_STEPS)) u_rot_dlon (
      .clock(clock), .enable(adv), .angle(t_dlon), .cos_out(cd), .sin_out(sd));

   // haversine and bearing products
   always_comb begin
      a_sum   = A_W'(m3_ll_ff) + A_W'(m3_qs_ff);
      a_clamp = a_sum;
      if (a_sum < 0) begin
         a_clamp = '0;
      end else if (a_sum > Q60_ONE) begin
         a_clamp = Q60_ONE;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         m1_cc_ff    <= PROD_W'(c1) * PROD_W'(c2);
         m1_ll_ff    <= PROD_W'(shlat) * PROD_W'(shlat);
         m1_sdc2_ff  <= PROD_W'(sd) * PROD_W'(c2);
         m1_c1s2_ff  <= PROD_W'(c1) * PROD_W'(s2);
         m1_s1c2_ff  <= PROD_W'(s1) * PROD_W'(c2);
         m1_shlon_ff <= shlon;
         m1_cd_ff    <= cd;

         m2_pq_ff    <= PROD_W'($signed(m1_cc_ff[Q_FRAC+TRIG_W-1:Q_FRAC])) * PROD_W'(m1_shlon_ff);
         m2_t3_ff    <= PROD_W'($signed(m1_s1c2_ff[Q_FRAC+TRIG_W-1:Q_FRAC])) * PROD_W'(m1_cd_ff);
         m2_ll_ff    <= m1_ll_ff;
         m2_shlon_ff <= m1_shlon_ff;
         m2_y_ff     <= m1_sdc2_ff[Q_FRAC+TRIG_W-1:Q_FRAC];
         m2_t1_ff    <= m1_c1s2_ff[Q_FRAC+TRIG_W-1:Q_FRAC];

         m3_qs_ff <= PROD_W'($signed(m2_pq_ff[Q_FRAC+TRIG_W-1:Q_FRAC])) * PROD_W'(m2_shlon_ff);
         m3_ll_ff <= m2_ll_ff;
         m3_x_ff  <= VEC_IN_W'(m2_t1_ff) - $signed(m2_t3_ff[Q_FRAC+VEC_IN_W-1:Q_FRAC]);
         m3_y_ff  <= VEC_IN_W'(m2_y_ff);

         m4_a_ff  <= a_clamp[SQ_IN_W-1:0];
         m4_na_ff <= SQ_IN_W'(Q60_ONE - a_clamp);
         m4_x_ff  <= m3_x_ff;
         m4_y_ff  <= m3_y_ff;
      end
   end

   gcn_isqrt u_sqrt_a (
      .clock(clock), .enable(adv), .val(m4_a_ff), .root(root_a));
   gcn_isqrt u_sqrt_na (
      .clock(clock), .enable(adv), .val(m4_na_ff), .root(root_na));

   gcn_delay #(.WIDTH(2 * VEC_IN_W), .DEPTH(SQ_STAGES)) u_bxy_delay (
      .clock(clock), .enable(adv), .din({m4_y_ff, m4_x_ff}), .dout(bxy_d));

   gcn_vector #(.STEPS(CORDIC_STEPS)) u_vec_dist (
      .clock(clock), .enable(adv),
      .x(VEC_IN_W'(root_na)), .y(VEC_IN_W'(root_a)), .z_out(vd_z));
   gcn_vector #(.STEPS(CORDIC_STEPS)) u_vec_bear (
      .clock(clock), .enable(adv),
      .x($signed(bxy_d[VEC_IN_W-1:0])), .y($signed(bxy_d[2*VEC_IN_W-1:VEC_IN_W])),
      .z_out(vb_z));

   gcn_delay #(.WIDTH(COG_W), .DEPTH(LAT_LEN - 1)) u_cog_delay (
      .clock(clock), .enable(adv), .din(cog), .dout(cog_d));

   // scaling, wrap and output register
   always_comb begin
      two_z    = vd_z[ZW-1] ? '0 : {vd_z[ZW-2:0], 1'b0};
      dist_raw = f1_dprod_ff[DP_W-1:32];
      bdeg_raw = BEAR_W'(f1_bprod_ff >> (32 - ANGLE_FRAC_BITS));
      corr_in  = $signed({2'b00, f2_bdeg_ff}) - $signed({2'b00, cog_d});
      if (corr_in > HALF_D) begin
         corr_in = corr_in - FULL_D;
      end else if (corr_in < -HALF_D) begin
         corr_in = corr_in + FULL_D;
      end
      if (corr_in > HALF_D) begin
         corr_in = HALF_D;
      end
      if (corr_in < -HALF_D) begin
         corr_in = -HALF_D;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         f1_dprod_ff <= DP_W'(two_z) * DP_W'(CIRC_NM_Q16) + DP_W'(64'h80000000);
         f1_bprod_ff <= BP_W'(vb_z[TURN_W-1:0]) * BP_W'(360) + BP_W'(BEAR_RND);

         f2_dist_ff <= (dist_raw > (DP_W-32)'(DIST_MAX)) ? DIST_MAX : dist_raw[DIST_W-1:0];
         f2_bdeg_ff <= (bdeg_raw >= BEAR_LIM) ? '0 : bdeg_raw;

         out_dist_ff   <= wp_valid_ff ? f2_dist_ff : '0;
         out_dvalid_ff <= wp_valid_ff;
         out_svalid_ff <= wp_valid_ff && nav_en_ff;
         out_bear_ff   <= (wp_valid_ff && nav_en_ff) ? f2_bdeg_ff : '0;
         out_corr_ff   <= (wp_valid_ff && nav_en_ff) ? corr_in[CORR_W-1:0] : '0;
      end
   end

   assign rsp_tvalid = valid_ff[LAT_LEN-1];
   assign rsp_tdata  = {{(RSP_DATA_W-DIST_W-BEAR_W-CORR_W){1'b0}},
                        out_corr_ff, out_bear_ff, out_dist_ff};
   assign rsp_tuser  = {out_svalid_ff, out_dvalid_ff};

   a_steer_needs_dist: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (!out_svalid_ff || out_dvalid_ff))
      else $error("steer_valid without distance_valid");

   a_dist_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (out_dist_ff <= DIST_MAX))
      else $error("distance above saturation limit");

   a_bear_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (out_bear_ff < BEAR_LIM))
      else $error("bearing not wrapped below full circle");

   a_no_waypoint_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !out_dvalid_ff) |-> (rsp_tdata == '0) && !out_svalid_ff)
      else $error("result not cleared without waypoint");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("pipeline not empty after reset");

endmodule
